>>> hw/rtl/gld_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gld_pkg
// Shared constants and types of the GIF LZW decoder.
// ----------------------------------------------------------------------------
package gld_pkg;

	localparam int TableDepth = 4096;
	localparam int TableAw    = $clog2(TableDepth);
	localparam int StackDepth = 4096;
	localparam int StackAw    = $clog2(StackDepth);
	localparam int CntW       = StackAw + 1;
	localparam int CodeW      = 12;
	localparam int AccW       = 20;
	localparam logic [3:0] MaxCodeBits = 4'd12;
	localparam logic [3:0] MinBitsLow  = 4'd2;
	localparam logic [3:0] MinBitsHigh = 4'd11;
	localparam logic [3:0] MinBitsRst  = 4'd8;
	localparam logic [12:0] NullPrefix = 13'd4096;

	// result status codes
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_END       = 3'd1;
	localparam logic [2:0] ST_ZERO_BLK  = 3'd2;
	localparam logic [2:0] ST_TBL_OVF   = 3'd3;
	localparam logic [2:0] ST_STK_OVF   = 3'd4;
	localparam logic [2:0] ST_LOOP      = 3'd5;
	localparam logic [2:0] ST_UNEXP     = 3'd6;

	localparam logic CMD_FETCH = 1'b1;

	// one classified request between front and back
	typedef struct packed {
		logic       fetch;
		logic [7:0] data;
	} gld_item_t;

endpackage
`default_nettype wire

>>> hw/rtl/gld_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gld_front
// Accepts requests, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module gld_front (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                in_valid,
	output logic               in_ready,
	input  wire                cmd,
	input  wire  [7:0]         data_byte,
	output gld_pkg::gld_item_t item,
	output logic               item_valid,
	input  wire                item_take
);
	import gld_pkg::*;

	gld_item_t  fifo_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       push;
	logic       pop;

	assign in_ready   = (cnt_q != 2'd2);
	assign item_valid = (cnt_q != 2'd0);
	assign item       = fifo_q[rd_ptr_q];
	assign push       = in_valid && in_ready;
	assign pop        = item_valid && item_take;

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q].fetch <= (cmd == CMD_FETCH);
			fifo_q[wr_ptr_q].data  <= data_byte;
		end
	end

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop)  rd_ptr_q <= ~rd_ptr_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule
`default_nettype wire

>>> hw/rtl/gld_engine.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gld_engine
// Carries out requests: bit unpacking, chain walk, table update, stack pops.
// ----------------------------------------------------------------------------
module gld_engine (
	input  wire                clk,
	input  wire                arst_n,
	input  gld_pkg::gld_item_t item,
	input  wire                item_valid,
	output logic               item_take,
	input  wire                cfg_write,
	input  wire  [3:0]         cfg_value,
	output logic               out_valid,
	input  wire                out_ready,
	output logic [7:0]         pixel,
	output logic               pixel_valid,
	output logic               need_byte,
	output logic [2:0]         status
);
	import gld_pkg::*;

	localparam logic [2:0] S_IDLE    = 3'd0;
	localparam logic [2:0] S_FETCH   = 3'd1;
	localparam logic [2:0] S_POPWAIT = 3'd2;
	localparam logic [2:0] S_WALK    = 3'd3;
	localparam logic [2:0] S_WWAIT   = 3'd4;
	localparam logic [2:0] S_FINISH  = 3'd5;

	localparam logic [1:0] M_FIRST   = 2'd0;
	localparam logic [1:0] M_NORMAL  = 2'd1;
	localparam logic [1:0] M_SPECIAL = 2'd2;

	// memories
	logic [CodeW+7:0] tbl_mem [TableDepth];
	logic [7:0]       stk_mem [StackDepth];
	logic [CodeW+7:0] tbl_rdata;
	logic [7:0]       stk_rdata;

	// state
	logic [2:0]         state_q,  state_d;
	logic [3:0]         min_q;
	logic [CntW-1:0]    cnt_q,    cnt_d;
	logic [AccW-1:0]    acc_q,    acc_d;
	logic [4:0]         bits_q,   bits_d;
	logic [7:0]         blk_q,    blk_d;
	logic [3:0]         ccb_q,    ccb_d;
	logic [12:0]        nfc_q,    nfc_d;
	logic [12:0]        prev_q,   prev_d;
	logic               stop_q,   stop_d;
	logic [2:0]         reason_q, reason_d;
	logic [12:0]        hw_q,     hw_d;
	logic [CodeW-1:0]   code_q,   code_d;
	logic [CodeW-1:0]   cur_q,    cur_d;
	logic [1:0]         mode_q,   mode_d;
	logic [StackAw-1:0] slot_q,   slot_d;
	logic [7:0]         first_q,  first_d;

	// memory controls
	logic               tb_we;
	logic [TableAw-1:0] tb_wa, tb_ra;
	logic [CodeW+7:0]   tb_wd;
	logic               st_we;
	logic [StackAw-1:0] st_wa, st_ra;
	logic [7:0]         st_wd;

	// result
	logic       res_load;
	logic [7:0] res_pixel;
	logic       res_pv, res_nb;
	logic [2:0] res_status;
	logic       out_free;

	logic [3:0]       cfg_sat;
	logic [12:0]      clr_code;
	logic [CodeW-1:0] width_mask, code_x;
	logic             cur_in_tbl;

	assign clr_code   = 13'd1 << min_q;
	assign width_mask = CodeW'((13'd1 << ccb_q) - 13'd1);
	assign code_x     = acc_q[CodeW-1:0] & width_mask;
	assign cur_in_tbl = ({1'b0, cur_q} >= clr_code + 13'd2) && ({1'b0, cur_q} < hw_q);
	assign out_free   = !out_valid || out_ready;
	assign cfg_sat    = (cfg_value < MinBitsLow) ? MinBitsLow :
	                    (cfg_value > MinBitsHigh) ? MinBitsHigh : cfg_value;

	// table memory
	always_ff @(posedge clk) begin
		if (tb_we) tbl_mem[tb_wa] <= tb_wd;
		tbl_rdata <= tbl_mem[tb_ra];
	end

	// string stack memory
	always_ff @(posedge clk) begin
		if (st_we) stk_mem[st_wa] <= st_wd;
		stk_rdata <= stk_mem[st_ra];
	end

	// sequencer
	always_comb begin
		state_d = state_q; cnt_d = cnt_q; acc_d = acc_q; bits_d = bits_q;
		blk_d = blk_q; ccb_d = ccb_q; nfc_d = nfc_q; prev_d = prev_q;
		stop_d = stop_q; reason_d = reason_q; hw_d = hw_q; code_d = code_q;
		cur_d = cur_q; mode_d = mode_q; slot_d = slot_q; first_d = first_q;
		tb_we = 1'b0; tb_wa = nfc_q[TableAw-1:0]; tb_wd = {prev_q[CodeW-1:0], first_q};
		tb_ra = cur_q;
		st_we = 1'b0; st_wa = cnt_q[StackAw-1:0]; st_wd = 8'd0;
		st_ra = StackAw'(cnt_q - CntW'(1));
		res_load = 1'b0; res_pixel = 8'd0; res_pv = 1'b0; res_nb = 1'b0;
		res_status = ST_OK;
		item_take = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (item_valid && out_free) begin
					if (stop_q) begin
						item_take = 1'b1;
						res_load = 1'b1; res_status = reason_q;
					end else if (!item.fetch) begin
						item_take = 1'b1;
						res_load = 1'b1;
						if (bits_q >= {1'b0, ccb_q}) begin
							res_status = ST_UNEXP;
						end else if (blk_q == 8'd0) begin
							if (item.data == 8'd0) begin
								stop_d = 1'b1; reason_d = ST_ZERO_BLK;
								res_status = ST_ZERO_BLK;
							end else begin
								blk_d = item.data;
							end
						end else begin
							acc_d  = acc_q | (AccW'(item.data) << bits_q);
							bits_d = bits_q + 5'd8;
							blk_d  = blk_q - 8'd1;
						end
						if (!stop_d)
							res_nb = (cnt_q == '0) && (bits_d < {1'b0, ccb_q});
					end else begin
						state_d = S_FETCH;
					end
				end
			end
			S_FETCH: begin
				if (cnt_q != '0) begin
					cnt_d = cnt_q - CntW'(1);
					state_d = S_POPWAIT;
				end else if (bits_q < {1'b0, ccb_q}) begin
					item_take = 1'b1; res_load = 1'b1; res_nb = 1'b1;
					state_d = S_IDLE;
				end else begin
					acc_d  = acc_q >> ccb_q;
					bits_d = bits_q - {1'b0, ccb_q};
					code_d = code_x;
					cur_d  = code_x;
					if ({1'b0, code_x} == clr_code + 13'd1) begin
						item_take = 1'b1; res_load = 1'b1; res_status = ST_END;
						stop_d = 1'b1; reason_d = ST_END; state_d = S_IDLE;
					end else if ({1'b0, code_x} == clr_code) begin
						ccb_d  = min_q + 4'd1;
						prev_d = NullPrefix;
						nfc_d  = clr_code + 13'd2;
					end else if (prev_q == NullPrefix) begin
						mode_d = M_FIRST; state_d = S_WALK;
					end else if ({1'b0, code_x} < nfc_q) begin
						mode_d = M_NORMAL; state_d = S_WALK;
					end else begin
						// code not yet in table: reserve a slot for its last char
						st_we  = 1'b1; st_wd = 8'd0;
						slot_d = cnt_q[StackAw-1:0];
						cnt_d  = cnt_q + CntW'(1);
						cur_d  = prev_q[CodeW-1:0];
						mode_d = M_SPECIAL; state_d = S_WALK;
					end
				end
			end
			S_POPWAIT: begin
				item_take = 1'b1; res_load = 1'b1;
				res_pixel = stk_rdata; res_pv = 1'b1;
				state_d = S_IDLE;
			end
			S_WALK: begin
				if (cur_in_tbl) begin
					state_d = S_WWAIT;
				end else if (cnt_q[CntW-1]) begin
					item_take = 1'b1; res_load = 1'b1; res_status = ST_STK_OVF;
					stop_d = 1'b1; reason_d = ST_STK_OVF; state_d = S_IDLE;
				end else begin
					// root of the chain
					st_we = 1'b1; st_wd = cur_q[7:0];
					cnt_d = cnt_q + CntW'(1);
					first_d = cur_q[7:0];
					state_d = S_FINISH;
				end
			end
			S_WWAIT: begin
				if (cnt_q[CntW-1]) begin
					item_take = 1'b1; res_load = 1'b1; res_status = ST_STK_OVF;
					stop_d = 1'b1; reason_d = ST_STK_OVF; state_d = S_IDLE;
				end else begin
					st_we = 1'b1; st_wd = tbl_rdata[7:0];
					cnt_d = cnt_q + CntW'(1);
					cur_d = tbl_rdata[CodeW+7:8];
					state_d = S_WALK;
				end
			end
			S_FINISH: begin
				state_d = S_FETCH;
				if (mode_q == M_FIRST) begin
					prev_d = {1'b0, code_q};
				end else begin
					if (mode_q == M_SPECIAL) begin
						st_we = 1'b1; st_wa = slot_q; st_wd = first_q;
					end
					if (nfc_q[12]) begin
						item_take = 1'b1; res_load = 1'b1; res_status = ST_TBL_OVF;
						stop_d = 1'b1; reason_d = ST_TBL_OVF; state_d = S_IDLE;
					end else begin
						tb_we = 1'b1;
						if (nfc_q + 13'd1 > hw_q) hw_d = nfc_q + 13'd1;
						if (nfc_q == (13'd1 << ccb_q) - 13'd1 && ccb_q < MaxCodeBits)
							ccb_d = ccb_q + 4'd1;
						nfc_d  = nfc_q + 13'd1;
						prev_d = {1'b0, code_q};
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// state registers; a configuration write restarts the decoder
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE; min_q <= MinBitsRst; cnt_q <= '0; acc_q <= '0;
			bits_q <= '0; blk_q <= '0; ccb_q <= MinBitsRst + 4'd1;
			nfc_q <= (13'd1 << MinBitsRst) + 13'd2; prev_q <= NullPrefix;
			stop_q <= 1'b0; reason_q <= ST_OK; hw_q <= '0;
			mode_q <= M_FIRST;
			out_valid <= 1'b0;
		end else begin
			if (cfg_write) begin
				state_q <= S_IDLE; min_q <= cfg_sat; cnt_q <= '0; acc_q <= '0;
				bits_q <= '0; blk_q <= '0; ccb_q <= cfg_sat + 4'd1;
				nfc_q <= (13'd1 << cfg_sat) + 13'd2; prev_q <= NullPrefix;
				stop_q <= 1'b0; reason_q <= ST_OK; hw_q <= '0;
			end else begin
				state_q <= state_d; cnt_q <= cnt_d; acc_q <= acc_d; bits_q <= bits_d;
				blk_q <= blk_d; ccb_q <= ccb_d; nfc_q <= nfc_d; prev_q <= prev_d;
				stop_q <= stop_d; reason_q <= reason_d; hw_q <= hw_d;
			end
			mode_q <= mode_d;
			if (res_load)       out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		code_q <= code_d; cur_q <= cur_d; slot_q <= slot_d; first_q <= first_d;
		if (res_load) begin
			pixel <= res_pixel; pixel_valid <= res_pv;
			need_byte <= res_nb; status <= res_status;
		end
	end

endmodule
`default_nettype wire

>>> hw/rtl/gif_lzw_decoder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gif_lzw_decoder
// Pull-style GIF LZW decoder: stream bytes in, one result per request out.
// ----------------------------------------------------------------------------
//  channel | signals                               | dir
//  in      | in_valid/in_ready, cmd, data_byte     | in
//  out     | out_valid/out_ready, pixel,           | out
//          | pixel_valid, need_byte, status        |
//  cfg     | cfg_valid/cfg_ready, cfg_data         | in
//
// A stream byte takes S_IDLE, a stack pop S_FETCH and S_POPWAIT (stack read).
// A new code is decoded in S_FETCH, each link of its prefix chain in S_WALK
// and S_WWAIT (a table read each), and its root and the table update in S_WALK
// and S_FINISH before its first pop; a clear code in S_FETCH. A two-entry
// queue decouples intake from the engine; the engine starts a request only
// when the output register is free or being drained. Reset and configuration
// writes restart the decoder at once; unwritten table entries are never read.
module gif_lzw_decoder (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        in_valid,
	output logic       in_ready,
	input  wire        cmd,
	input  wire  [7:0] data_byte,
	output logic       out_valid,
	input  wire        out_ready,
	output logic [7:0] pixel,
	output logic       pixel_valid,
	output logic       need_byte,
	output logic [2:0] status,
	input  wire        cfg_valid,
	output logic       cfg_ready,
	input  wire  [3:0] cfg_data
);
	import gld_pkg::*;

	gld_item_t item;
	logic      item_valid;
	logic      item_take;

	assign cfg_ready = 1'b1;

	gld_front u_front (
		.clk, .arst_n, .in_valid, .in_ready, .cmd, .data_byte,
		.item, .item_valid, .item_take
	);

	gld_engine u_engine (
		.clk, .arst_n, .item, .item_valid, .item_take,
		.cfg_write (cfg_valid), .cfg_value (cfg_data),
		.out_valid, .out_ready, .pixel, .pixel_valid, .need_byte, .status
	);

endmodule
`default_nettype wire

>>> hw/rtl/gld_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gld_checker
// Port-level checks of the decoder, bound to the top level.
// ----------------------------------------------------------------------------
module gld_checker (
	input wire       clk,
	input wire       arst_n,
	input wire       out_valid,
	input wire       out_ready,
	input wire [7:0] pixel,
	input wire       pixel_valid,
	input wire       need_byte,
	input wire [2:0] status
);
	import gld_pkg::*;

	// a pixel comes with ok status and no byte request
	a_pix_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && pixel_valid |-> status == ST_OK && !need_byte)
		else $error("pixel with status or need_byte");

	// a byte request comes only with status ST_OK or ST_UNEXP
	a_nb_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && need_byte |-> status == ST_OK || status == ST_UNEXP)
		else $error("need_byte with error status");

	// status stays in its defined range
	a_st_rng: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status != 3'd7)
		else $error("undefined status");

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pixel) && $stable(status))
		else $error("stalled result changed");

endmodule

bind gif_lzw_decoder gld_checker u_gld_checker (
	.clk, .arst_n, .out_valid, .out_ready,
	.pixel, .pixel_valid, .need_byte, .status
);
`default_nettype wire

>>> tb/gif_lzw_decoder_test.sv
// ----------------------------------------------------------------------------
// gif_lzw_decoder_test
// Self-checking bench for the GIF LZW decoder. LZW code streams are built
// with random content, packed LSB first into sub-blocks and fed as stream
// bytes and pixel fetches. An in-bench decoder model predicts every result.
// Both channels idle at random, and the output side stalls once for a long
// stretch.
// ----------------------------------------------------------------------------
module gif_lzw_decoder_test;
	timeunit 1ns;
	timeprecision 1ps;

	import gld_pkg::*;

	typedef struct packed {
		logic [7:0] pixel;
		logic       pixel_valid;
		logic       need_byte;
		logic [2:0] status;
	} pix_res_t;

	typedef struct packed {
		logic       cmd;
		logic [7:0] data;
	} dec_req_t;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic       cmd;
	logic [7:0] data_byte;
	logic       out_valid;
	logic       out_ready;
	logic [7:0] pixel;
	logic       pixel_valid;
	logic       need_byte;
	logic [2:0] status;
	logic       cfg_valid;
	logic       cfg_ready;
	logic [3:0] cfg_data;

	gif_lzw_decoder DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .cmd(cmd), .data_byte(data_byte),
		.out_valid(out_valid), .out_ready(out_ready), .pixel(pixel),
		.pixel_valid(pixel_valid), .need_byte(need_byte), .status(status),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	dec_req_t req_q[$];
	pix_res_t pix_expected_q[$];
	int       mismatch_cnt;
	int       result_cnt;
	bit       calm;
	bit       stim_done;

	// ---------------- decoder model state ----------------
	int         m_min_bits;
	int         m_prefix [TableDepth];
	logic [7:0] m_suffix [TableDepth];
	logic [7:0] m_stack [StackDepth];
	int         m_sp;
	int         m_acc;
	int         m_nacc;
	int         m_blk_left;
	int         m_width;
	int         m_next_free;
	int         m_prev;
	bit         m_stopped;
	logic [2:0] m_stop_code;

	function automatic void lzw_restart();
		for (int i = 0; i < TableDepth; i++) begin
			m_prefix[i] = int'(NullPrefix);
			m_suffix[i] = i[7:0];
		end
		m_sp = 0;
		m_acc = 0;
		m_nacc = 0;
		m_blk_left = 0;
		m_width = m_min_bits + 1;
		m_next_free = (1 << m_min_bits) + 2;
		m_prev = int'(NullPrefix);
		m_stopped = 0;
		m_stop_code = ST_OK;
	endfunction

	// push string of code, last character first
	function automatic logic [2:0] stack_chain(int code, output logic [7:0] first);
		int guard;
		guard = 0;
		first = '0;
		while (code < TableDepth && m_prefix[code] != NullPrefix) begin
			guard++;
			if (guard == 'hffff)
				return ST_LOOP;
			if (m_sp >= StackDepth)
				break;
			m_stack[m_sp] = m_suffix[code];
			m_sp++;
			code = m_prefix[code];
		end
		if (code >= TableDepth)
			return ST_TBL_OVF;
		if (m_sp >= StackDepth)
			return ST_STK_OVF;
		m_stack[m_sp] = m_suffix[code];
		m_sp++;
		first = m_suffix[code];
		return ST_OK;
	endfunction

	function automatic logic [2:0] expand_code(int code);
		logic [7:0] first;
		logic [2:0] st;
		int         slot;
		if (m_prev == NullPrefix) begin
			st = stack_chain(code, first);
			if (st != ST_OK)
				return st;
			m_prev = code;
			return ST_OK;
		end
		if (code < m_next_free) begin
			st = stack_chain(code, first);
			if (st != ST_OK)
				return st;
		end else begin
			// code not yet in table: first char of previous string goes last
			if (m_sp >= StackDepth)
				return ST_STK_OVF;
			slot = m_sp;
			m_stack[m_sp] = '0;
			m_sp++;
			st = stack_chain(m_prev, first);
			if (st != ST_OK)
				return st;
			m_stack[slot] = first;
		end
		if (m_next_free >= TableDepth)
			return ST_TBL_OVF;
		m_prefix[m_next_free] = m_prev;
		m_suffix[m_next_free] = first;
		if (m_next_free == (1 << m_width) - 1 && m_width < MaxCodeBits)
			m_width++;
		m_next_free++;
		m_prev = code;
		return ST_OK;
	endfunction

	function automatic pix_res_t decode_step(logic c, logic [7:0] b);
		pix_res_t r;
		int       clr;
		int       code;
		logic [2:0] st;
		r = '0;
		clr = 1 << m_min_bits;
		if (m_stopped) begin
			r.status = m_stop_code;
			return r;
		end
		if (c != CMD_FETCH) begin
			if (m_nacc >= m_width)
				r.status = ST_UNEXP;
			else if (m_blk_left == 0) begin
				if (b == 0) begin
					m_stopped = 1;
					m_stop_code = ST_ZERO_BLK;
					r.status = ST_ZERO_BLK;
					return r;
				end
				m_blk_left = int'(b);
			end else begin
				m_acc = (m_acc | (int'(b) << m_nacc)) & 'hfffff;
				m_nacc += 8;
				m_blk_left--;
			end
			r.need_byte = (m_sp == 0 && m_nacc < m_width);
			return r;
		end
		while (m_sp == 0) begin
			if (m_nacc < m_width) begin
				r.need_byte = 1;
				return r;
			end
			code = m_acc & ((1 << m_width) - 1);
			m_acc = m_acc >> m_width;
			m_nacc -= m_width;
			if (code == clr + 1) begin
				m_stopped = 1;
				m_stop_code = ST_END;
				r.status = ST_END;
				return r;
			end
			if (code == clr) begin
				m_width = m_min_bits + 1;
				m_prev = int'(NullPrefix);
				m_next_free = clr + 2;
				continue;
			end
			st = expand_code(code);
			if (st != ST_OK) begin
				m_stopped = 1;
				m_stop_code = st;
				r.status = st;
				return r;
			end
		end
		m_sp--;
		r.pixel = m_stack[m_sp];
		r.pixel_valid = 1;
		return r;
	endfunction

	// ---------------- clock, reset, limit ----------------
	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("Regression FAIL");
		$finish;
	end

	// mostly short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 19);
		if (r < 12)
			return 0;
		if (r < 18)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// ---------------- request driver ----------------
	int send_gap;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 0;
			cmd <= 0;
			data_byte <= '0;
			send_gap <= 0;
		end else if (!in_valid || in_ready) begin
			if (send_gap > 0) begin
				send_gap <= send_gap - 1;
				in_valid <= 0;
			end else if (req_q.size() > 0) begin
				in_valid <= 1;
				cmd <= req_q[0].cmd;
				data_byte <= req_q[0].data;
				void'(req_q.pop_front());
				send_gap <= calm ? 0 : pick_gap();
			end else begin
				in_valid <= 0;
			end
		end
	end

	// ---------------- result monitor ----------------
	int       recv_gap;
	pix_res_t got;
	pix_res_t want;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 0;
			recv_gap <= 0;
		end else begin
			if (out_valid && out_ready) begin
				got = '{pixel, pixel_valid, need_byte, status};
				result_cnt <= result_cnt + 1;
				if (pix_expected_q.size() == 0) begin
					mismatch_cnt++;
					if (mismatch_cnt <= 10)
						$display("unexpected result %h", got);
				end else begin
					want = pix_expected_q.pop_front();
					if (got !== want) begin
						mismatch_cnt++;
						if (mismatch_cnt <= 10)
							$display("mismatch: exp pix=%h pv=%b nb=%b st=%0d got pix=%h pv=%b nb=%b st=%0d",
								want.pixel, want.pixel_valid, want.need_byte, want.status,
								got.pixel, got.pixel_valid, got.need_byte, got.status);
					end
				end
			end
			// one long hold-off while requests keep coming
			if (result_cnt == 150 && out_valid && out_ready) begin
				out_ready <= 0;
				recv_gap <= 300;
			end else if (recv_gap > 0) begin
				out_ready <= 0;
				recv_gap <= recv_gap - 1;
			end else if (calm) begin
				out_ready <= 1;
			end else begin
				out_ready <= 1;
				recv_gap <= pick_gap();
			end
		end
	end

	// ---------------- stimulus ----------------
	int   code_q[$];
	int   width_q[$];
	logic [7:0] stream_q[$];

	task automatic add_req(logic c, logic [7:0] b);
		pix_expected_q.push_back(decode_step(c, b));
		req_q.push_back('{c, b});
	endtask

	task automatic write_min_bits(logic [3:0] v);
		wait (req_q.size() == 0 && !in_valid && pix_expected_q.size() == 0);
		repeat (30) @(posedge clk);
		cfg_data <= v;
		cfg_valid <= 1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
		m_min_bits = int'((v < MinBitsLow) ? MinBitsLow : (v > MinBitsHigh) ? MinBitsHigh : v);
		lzw_restart();
	endtask

	// codes for one image, mirroring the decoder's table growth
	task automatic build_codes(int ncodes, int mode);
		int clr, w, nf, c, r;
		bit first;
		clr = 1 << m_min_bits;
		w = m_min_bits + 1;
		nf = clr + 2;
		first = 1;
		code_q.delete();
		width_q.delete();
		code_q.push_back(clr);
		width_q.push_back(w);
		for (int k = 0; k < ncodes; k++) begin
			r = $urandom_range(0, 99);
			if (!first && mode != 1 && r < 3) begin
				code_q.push_back(clr);
				width_q.push_back(w);
				w = m_min_bits + 1;
				nf = clr + 2;
				first = 1;
				continue;
			end
			if (first || mode == 1 || r < 55)
				c = $urandom_range(0, clr - 1);
			else if (r < 80 && nf > clr + 2)
				c = $urandom_range(clr + 2, nf - 1);
			else if (r < 93 || mode == 0)
				c = (nf < (1 << w)) ? nf : $urandom_range(0, clr - 1);
			else begin
				c = $urandom_range(0, (1 << w) - 1);
				if (c == clr || c == clr + 1)
					c = 0;
			end
			code_q.push_back(c);
			width_q.push_back(w);
			if (!first) begin
				if (nf == (1 << w) - 1 && w < MaxCodeBits)
					w++;
				nf++;
			end
			first = 0;
		end
		code_q.push_back(clr + 1);
		width_q.push_back(w);
	endtask

	// pack codes LSB first into sub-blocks of up to blk_max bytes
	task automatic pack_stream(int blk_max);
		logic [7:0] raw[$];
		logic [7:0] cur;
		int nb, len, pos;
		cur = '0;
		nb = 0;
		raw.delete();
		stream_q.delete();
		foreach (code_q[i]) begin
			for (int j = 0; j < width_q[i]; j++) begin
				cur[nb] = code_q[i][j];
				nb++;
				if (nb == 8) begin
					raw.push_back(cur);
					cur = '0;
					nb = 0;
				end
			end
		end
		if (nb > 0)
			raw.push_back(cur);
		pos = 0;
		while (pos < raw.size()) begin
			len = $urandom_range(1, blk_max);
			if (len > raw.size() - pos)
				len = raw.size() - pos;
			stream_q.push_back(len[7:0]);
			for (int j = 0; j < len; j++)
				stream_q.push_back(raw[pos + j]);
			pos += len;
		end
	endtask

	// feed a stream, fetching pixels whenever the decoder holds some
	task automatic run_image(int noise_pct);
		bit need;
		while (!m_stopped) begin
			need = (m_sp == 0 && m_nacc < m_width);
			if ($urandom_range(0, 99) < noise_pct) begin
				if (need)
					add_req(CMD_FETCH, 8'($urandom()));
				else
					add_req(~CMD_FETCH, 8'($urandom()));
			end else if (need) begin
				if (stream_q.size() == 0)
					break;
				add_req(~CMD_FETCH, stream_q.pop_front());
			end else begin
				add_req(CMD_FETCH, 8'($urandom()));
			end
		end
		// a couple of requests after the stop
		add_req(~CMD_FETCH, 8'($urandom()));
		add_req(CMD_FETCH, 8'($urandom()));
	endtask

	initial begin
		int nimg;
		mismatch_cnt = 0;
		result_cnt = 0;
		calm = 0;
		stim_done = 0;
		arst_n = 0;
		cfg_valid = 0;
		cfg_data = '0;
		m_min_bits = int'(MinBitsRst);
		lzw_restart();
		repeat (8) @(posedge clk);
		arst_n <= 1;

		// directed: reset width, early fetch, short image with extreme bytes
		add_req(CMD_FETCH, 8'hff);
		add_req(~CMD_FETCH, 8'h00 + 8'd3);
		build_codes(6, 0);
		pack_stream(255);
		run_image(0);

		// zero-length sub-block, then register saturation at both ends
		write_min_bits(4'd5);
		add_req(~CMD_FETCH, 8'h00);
		add_req(CMD_FETCH, 8'h00);
		write_min_bits(4'd0);
		build_codes(12, 0);
		pack_stream(3);
		run_image(0);
		write_min_bits(4'hf);
		build_codes(8, 0);
		pack_stream(255);
		run_image(0);

		// random images of various code sizes
		nimg = 0;
		while (result_cnt + pix_expected_q.size() < 340 && nimg < 40) begin
			write_min_bits(4'($urandom_range(0, 15)));
			calm = ($urandom_range(0, 3) == 0);
			build_codes($urandom_range(8, 30), ($urandom_range(0, 4) == 0) ? 2 : 0);
			pack_stream(($urandom_range(0, 3) == 0) ? 255 : $urandom_range(1, 12));
			run_image(($urandom_range(0, 2) == 0) ? 6 : 0);
			nimg++;
		end

		// ends on the smallest width again
		calm = 0;
		write_min_bits(4'd2);
		build_codes(30, 2);
		pack_stream(4);
		run_image(3);

		wait (req_q.size() == 0 && !in_valid && pix_expected_q.size() == 0);
		repeat (100) @(posedge clk);
		if (mismatch_cnt == 0 && pix_expected_q.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
